// ===== design/assert_macros.svh =====
// Assertion macros used by the digit core of the exponent window digit extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define EWD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequence must hold in the same cycle as the antecedent.
`define EWD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define EWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define EWD_ASSERT_ALWAYS(lbl, cond, msg)
`define EWD_ASSERT_SAME(lbl, ante, cons, msg)
`define EWD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/ewd_pkg.sv =====
// Types and constants of the exponent window digit extractor.
package ewd_pkg;

	localparam int MAX_EXPONENT_BYTES = 512;
	localparam int LEN_LIMIT = (MAX_EXPONENT_BYTES > 1023) ? 1023 :
		((MAX_EXPONENT_BYTES < 1) ? 1 : MAX_EXPONENT_BYTES);

	localparam int BYTE_W      = 8;
	localparam int DIGIT_W     = 8;
	localparam int WIDTH_REG_W = 4;
	localparam int LEN_REG_W   = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	// Register indexes of the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_WIDTH   = 2'd0,
		REG_EXPONENT_BYTES = 2'd1
	} ewd_reg_t;

	// Effective configuration handed to the digit core
	typedef struct packed {
		logic [WIDTH_REG_W-1:0] width;
		logic [LEN_REG_W-1:0]   length;
		logic [WIDTH_REG_W-1:0] first_need;
		logic                   restart;
	} ewd_cfg_t;

endpackage

// ===== design/ewd_if.sv =====
// Handshake interfaces: exponent bytes in, window digits out, register writes.
interface ewd_byte_if;
	import ewd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] exponent_byte;
	modport source (output valid, output exponent_byte, input ready);
	modport sink (input valid, input exponent_byte, output ready);
endinterface

interface ewd_digit_if;
	import ewd_pkg::*;
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic               run_end;
	logic               exponent_end;
	modport source (output valid, output digit, output run_end, output exponent_end,
		input ready);
	modport sink (input valid, input digit, input run_end, input exponent_end,
		output ready);
endinterface

interface ewd_cfg_if;
	import ewd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ewd_cfg.sv =====
// Configuration registers, clamping and first-digit length of the digit extractor.
module ewd_cfg (
	input  logic             clk,
	input  logic             arst_n,
	ewd_cfg_if.sink          cfg,
	output ewd_pkg::ewd_cfg_t conf
);
	import ewd_pkg::*;

	logic [WIDTH_REG_W-1:0] window_q;
	logic [LEN_REG_W-1:0]   length_q;
	logic [WIDTH_REG_W-1:0] width_eff;
	logic [LEN_REG_W-1:0]   length_eff;
	logic                   wr;
	logic [1:0]             r3;
	logic [2:0]             r5;
	logic [2:0]             r7;
	logic [WIDTH_REG_W-1:0] lead_bits;

	// Remainder by 3: base-4 digits sum to the same residue
	function automatic logic [1:0] mod3(input logic [LEN_REG_W-1:0] x);
		logic [3:0] s;
		logic [2:0] t;
		s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[9:8]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		if (t >= 3'd3) t = t - 3'd3;
		if (t >= 3'd3) t = t - 3'd3;
		return t[1:0];
	endfunction

	// Remainder by 5: base-16 digits sum to the same residue
	function automatic logic [2:0] mod5(input logic [LEN_REG_W-1:0] x);
		logic [5:0] s;
		logic [4:0] t;
		s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[9:8]);
		t = 5'(s[3:0]) + 5'(s[5:4]);
		for (int i = 0; i < 3; i++) begin
			if (t >= 5'd5) t = t - 5'd5;
		end
		return t[2:0];
	endfunction

	// Remainder by 7: base-8 digits sum to the same residue
	function automatic logic [2:0] mod7(input logic [LEN_REG_W-1:0] x);
		logic [4:0] s;
		logic [3:0] t;
		s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
		t = 4'(s[2:0]) + 4'(s[4:3]);
		if (t >= 4'd7) t = t - 4'd7;
		return t[2:0];
	endfunction

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid && cfg.ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIDTH_REG_W'(4);
			length_q <= LEN_REG_W'(1);
		end else if (wr) begin
			case (cfg.index)
				REG_WINDOW_WIDTH:   window_q <= cfg.data[WIDTH_REG_W-1:0];
				REG_EXPONENT_BYTES: length_q <= cfg.data[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp out-of-range settings
	always_comb begin
		if (window_q == '0) width_eff = WIDTH_REG_W'(1);
		else if (window_q > WIDTH_REG_W'(8)) width_eff = WIDTH_REG_W'(8);
		else width_eff = window_q;

		if (length_q == '0) length_eff = LEN_REG_W'(1);
		else if (length_q > LEN_REG_W'(LEN_LIMIT)) length_eff = LEN_REG_W'(LEN_LIMIT);
		else length_eff = length_q;
	end

	// Leading digit takes (length * 8) mod width bits, a full window when zero
	always_comb begin
		r3 = mod3(length_eff);
		r5 = mod5(length_eff);
		r7 = mod7(length_eff);
		case (width_eff)
			4'd3: lead_bits = (r3 == 2'd1) ? 4'd2 : ((r3 == 2'd2) ? 4'd1 : 4'd0);
			4'd5: begin
				case (r5)
					3'd1:    lead_bits = 4'd3;
					3'd2:    lead_bits = 4'd1;
					3'd3:    lead_bits = 4'd4;
					3'd4:    lead_bits = 4'd2;
					default: lead_bits = 4'd0;
				endcase
			end
			4'd6: lead_bits = {1'b0, r3, 1'b0};
			4'd7: lead_bits = {1'b0, r7};
			default: lead_bits = 4'd0;
		endcase
	end

	assign conf.width      = width_eff;
	assign conf.length     = length_eff;
	assign conf.first_need = (lead_bits == '0) ? width_eff : lead_bits;
	assign conf.restart    = wr && (cfg.index == REG_WINDOW_WIDTH ||
		cfg.index == REG_EXPONENT_BYTES);

endmodule

// ===== design/ewd_core.sv =====
// Byte work register, digit extraction step, stream state and result register.
`include "assert_macros.svh"

module ewd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  ewd_pkg::ewd_cfg_t conf,
	ewd_byte_if.sink          exp_bytes,
	ewd_digit_if.source       digits
);
	import ewd_pkg::*;

	// Stream state
	logic [6:0]           carry_bits_q;
	logic [2:0]           carry_count_q;
	logic                 first_pending_q;
	logic [LEN_REG_W-1:0] bytes_seen_q;

	// Work register of the byte in flight
	logic        busy_q;
	logic [14:0] acc_q;
	logic [3:0]  avail_q;
	logic [3:0]  need_q;
	logic [2:0]  cnt_q;
	logic        last_q;

	// Result register
	logic               out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               run_end_q;
	logic               exp_end_q;

	logic               emit;
	logic               fin;
	logic               accept;
	logic [3:0]         shift;
	logic [DIGIT_W-1:0] digit_val;
	logic [2:0]         cc_new;
	logic [6:0]         bits_new;
	logic [6:0]         cur_bits;
	logic [2:0]         cur_cnt;
	logic               byte_last;

	// Extraction step: take the top need_q of the avail_q bits held, leaving the rest below
	always_comb begin
		emit      = busy_q && (!out_valid_q || digits.ready);
		shift     = avail_q - need_q;
		digit_val = 8'(acc_q >> shift) & 8'((9'd1 << need_q) - 9'd1);
		fin       = (shift < conf.width) || (cnt_q == 3'd7);
		cc_new    = (shift > 4'd7) ? 3'd7 : shift[2:0];
		bits_new  = acc_q[6:0] & 7'((8'd1 << cc_new) - 8'd1);
	end

	// Forward the leftover bits of a byte that finishes in this cycle
	always_comb begin
		if (emit && fin) begin
			cur_bits = last_q ? '0 : bits_new;
			cur_cnt  = last_q ? '0 : cc_new;
		end else begin
			cur_bits = carry_bits_q;
			cur_cnt  = carry_count_q;
		end
	end

	assign exp_bytes.ready = !busy_q || (emit && fin);
	assign accept    = exp_bytes.valid && exp_bytes.ready;
	assign byte_last = (11'(bytes_seen_q) + 11'd1) >= 11'(conf.length);

	// Stream state: count bytes, keep leftover bits, restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_bits_q    <= '0;
			carry_count_q   <= '0;
			first_pending_q <= 1'b1;
			bytes_seen_q    <= '0;
		end else if (conf.restart) begin
			carry_bits_q    <= '0;
			carry_count_q   <= '0;
			first_pending_q <= 1'b1;
			bytes_seen_q    <= '0;
		end else begin
			if (emit && fin) begin
				carry_bits_q  <= cur_bits;
				carry_count_q <= cur_cnt;
			end
			if (accept) begin
				first_pending_q <= byte_last;
				bytes_seen_q    <= byte_last ? '0 : bytes_seen_q + LEN_REG_W'(1);
			end
		end
	end

	// Work register: load on transfer, advance one digit per free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (emit && fin) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= {cur_bits, exp_bytes.exponent_byte};
			avail_q <= 4'(cur_cnt) + 4'd8;
			need_q  <= first_pending_q ? conf.first_need : conf.width;
			cnt_q   <= '0;
			last_q  <= byte_last;
		end else if (emit && !fin) begin
			avail_q <= shift;
			need_q  <= conf.width;
			cnt_q   <= cnt_q + 3'd1;
		end
	end

	// Result register: fill on emit, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (digits.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			digit_q   <= digit_val;
			run_end_q <= fin;
			exp_end_q <= fin && last_q;
		end
	end

	assign digits.valid        = out_valid_q;
	assign digits.digit        = digit_q;
	assign digits.run_end      = run_end_q;
	assign digits.exponent_end = exp_end_q;

	`EWD_ASSERT_ALWAYS(a_need_fits, !busy_q || need_q <= avail_q, "digit wider than bits held")
	`EWD_ASSERT_SAME(a_end_on_run, digits.valid && digits.exponent_end, digits.run_end, "exponent end without run end")
	`EWD_ASSERT_NEXT(a_restart_count, accept && byte_last, first_pending_q && bytes_seen_q == '0, "byte count not restarted")
	`EWD_ASSERT_NEXT(a_restart_carry, emit && fin && last_q && !accept, carry_count_q == '0, "leftover bits kept past exponent end")

endmodule

// ===== design/exponent_window_digit_extractor.sv =====
// A taken byte loads the work register; its digits then leave through the result register.
// Throughput: one digit per cycle while the output is free or taken; a byte gives 1..8 digits,
//   one each from the single extraction step that shifts one digit out of the work register.
// A byte is taken in the cycle its predecessor's last digit moves to the result register.
// Reset: window width 4, exponent length 1 byte, stream starts a new exponent, no result held.
module exponent_window_digit_extractor (
	input  logic         clk,
	input  logic         arst_n,
	ewd_cfg_if.sink      cfg,
	ewd_byte_if.sink     exp_bytes,
	ewd_digit_if.source  digits
);
	import ewd_pkg::*;

	ewd_cfg_t conf;

	ewd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.conf   (conf)
	);

	ewd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.conf      (conf),
		.exp_bytes (exp_bytes),
		.digits    (digits)
	);

endmodule
